// ===== rtl/ddms_pkg.sv =====
// ----------------------------------------------------------------------------
// ddms_pkg - shared types and constants for the ddmin sequencer
// Request payload types, count widths, opcodes and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package ddms_pkg;

  // default maximum number of items tracked in the membership mask
  localparam int MAX_ITEMS_DEF = 32;

  // widths of the request fields
  localparam int CNT_W  = 6;
  localparam int MASK_W = 32;
  localparam int EXT_W  = CNT_W + 1;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_ITEM_COUNT = 3'd0;
  localparam logic [CNT_W-1:0]      ITEM_COUNT_RST = 6'd32;

  // opcodes
  localparam logic OP_START  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic opcode;
    logic crashed;
  } in_item_t;

  typedef struct packed {
    logic [MASK_W-1:0] trial_mask;
    logic              done_res;
    logic [CNT_W-1:0]  kept_count;
  } out_item_t;

endpackage : ddms_pkg

`default_nettype wire

// ===== rtl/ddms_div.sv =====
// ----------------------------------------------------------------------------
// ddms_div - iterative restoring divider
// Produces one quotient bit per cycle; done is high for a single cycle once the last bit is in the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module ddms_div (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [ddms_pkg::EXT_W-1:0] dividend,
  input  wire [ddms_pkg::CNT_W-1:0] divisor,
  output logic                     busy,
  output logic                     done,
  output logic [ddms_pkg::EXT_W-1:0] quotient
);
  import ddms_pkg::*;

  localparam int STEP_W = $clog2(EXT_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [EXT_W-1:0]   quo_r, quo_nxt;
  logic [CNT_W-1:0]   dvs_r, dvs_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [EXT_W-1:0]   rem_sh;
  logic [EXT_W-1:0]   rem_sub;

  // shift in next dividend bit and try the subtraction
  assign rem_sh  = {rem_r, quo_r[EXT_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sub[CNT_W-1:0];
        quo_nxt = {quo_r[EXT_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[CNT_W-1:0];
        quo_nxt = {quo_r[EXT_W-2:0], 1'b0};
      end
      if (step_r == STEP_W'(EXT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    quo_r  <= quo_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule : ddms_div

`default_nettype wire

// ===== rtl/delta_debug_min_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// delta_debug_min_sequencer_core - complement-only ddmin search sequencer
// Holds the current item set as a mask and proposes one trial per request.
// ----------------------------------------------------------------------------
// Usage: program item_count over the APB port while idle. Send an input
// request with opcode start to search item_count items (capped at MAX_ITEMS), then
// test each returned trial_mask externally and send opcode report with
// crashed set if the trial still fails. Every input request yields exactly
// one result request: the next trial, or the final set with done_res high.
// A report while no search runs returns the done result unchanged.
// A trial is built by a rank scan of one mask bit per cycle. Each recompute of
// the chunk size (start, failed trial, granularity step) runs an iterative
// division, and a granularity step makes an extra pass through the proposal
// state. in_stall stays high while a request is being worked on. The
// finished result sits in an output register, so a new input is taken while
// out_stall holds the last result; the block then waits before loading the
// next one. Reset clears the sets and counts, leaves item_count at 32 and the
// output channel empty.
// ----------------------------------------------------------------------------
`default_nettype none

module delta_debug_min_sequencer_core #(
  parameter int MAX_ITEMS = ddms_pkg::MAX_ITEMS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // input requests
  input  wire                          in_valid,
  output logic                         in_stall,
  input  ddms_pkg::in_item_t           in_data,
  // result requests
  output logic                         out_valid,
  input  wire                          out_stall,
  output ddms_pkg::out_item_t          out_data,
  // configuration
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [ddms_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire [ddms_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ddms_pkg::CFG_DATA_W-1:0] prdata,
  output logic                         pready
);
  import ddms_pkg::*;

  localparam int IDX_W = $clog2(MAX_ITEMS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_PROP,
    S_SCAN,
    S_OUT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       item_count_r, item_count_nxt;
  logic [MAX_ITEMS-1:0]   cur_set_r, cur_set_nxt;
  logic [MAX_ITEMS-1:0]   prop_set_r, prop_set_nxt;
  logic [CNT_W-1:0]       size_r, size_nxt;
  logic [CNT_W-1:0]       gran_r, gran_nxt;
  logic [CNT_W-1:0]       chunk_r, chunk_nxt;
  logic [EXT_W-1:0]       start_r, start_nxt;
  logic [EXT_W-1:0]       end_r, end_nxt;
  logic [CNT_W-1:0]       csize_r, csize_nxt;
  logic                   searching_r, searching_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [EXT_W-1:0]       rank_r, rank_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  logic                   in_acc;
  logic                   cfg_wr;
  logic [CNT_W-1:0]       sat_cnt;
  logic [MAX_ITEMS-1:0]   full_set;
  logic [EXT_W-1:0]       chunk_end;
  logic [EXT_W-1:0]       gran_dbl;
  logic [EXT_W-1:0]       removed;
  logic                   cur_bit;
  logic                   div_start;
  logic                   div_busy;
  logic                   div_done;
  logic [EXT_W-1:0]       div_dividend;
  logic [EXT_W-1:0]       div_quo;
  logic [MASK_W-1:0]      mask_out;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[CFG_ADDR_W-1] == REG_ITEM_COUNT[CFG_ADDR_W-1]);
  assign prdata = (paddr[CFG_ADDR_W-1] == REG_ITEM_COUNT[CFG_ADDR_W-1])
                  ? {{(CFG_DATA_W-CNT_W){1'b0}}, item_count_r} : '0;
  assign item_count_nxt = cfg_wr ? pwdata[CNT_W-1:0] : item_count_r;

  // handshakes
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // item count saturated to the mask width and its initial set
  always_comb begin
    if ({1'b0, item_count_r} > EXT_W'(MAX_ITEMS)) begin
      sat_cnt = CNT_W'(MAX_ITEMS);
    end else begin
      sat_cnt = item_count_r;
    end
    for (int k = 0; k < MAX_ITEMS; k++) begin
      full_set[k] = (EXT_W'(k) < {1'b0, sat_cnt});
    end
  end

  // chunk size division: ceil(size / granularity)
  assign div_dividend = {1'b0, size_r} + {1'b0, gran_r} - EXT_W'(1);
  assign div_start    = (state_r == S_DIV) && !div_busy && !div_done;

  ddms_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (gran_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // helpers for the proposal step
  assign chunk_end = start_r + {1'b0, csize_r};
  assign gran_dbl  = {gran_r, 1'b0};
  assign removed   = end_r - start_r;
  assign cur_bit   = cur_set_r[idx_r];

  // result mask resized to the output field
  always_comb begin
    for (int k = 0; k < MASK_W; k++) begin
      if (k < MAX_ITEMS) begin
        mask_out[k] = searching_r ? prop_set_r[k] : cur_set_r[k];
      end else begin
        mask_out[k] = 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_set_nxt   = cur_set_r;
    prop_set_nxt  = prop_set_r;
    size_nxt      = size_r;
    gran_nxt      = gran_r;
    chunk_nxt     = chunk_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    csize_nxt     = csize_r;
    searching_nxt = searching_r;
    idx_nxt       = idx_r;
    rank_nxt      = rank_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.opcode == OP_START) begin
            cur_set_nxt  = full_set;
            prop_set_nxt = '0;
            size_nxt     = sat_cnt;
            gran_nxt     = CNT_W'(2);
            chunk_nxt    = '0;
            start_nxt    = '0;
            state_nxt    = S_DIV;
          end else if (searching_r) begin
            if (in_data.crashed) begin
              cur_set_nxt = prop_set_r;
              size_nxt    = size_r - removed[CNT_W-1:0];
              gran_nxt    = CNT_W'(2);
              chunk_nxt   = '0;
              start_nxt   = '0;
              state_nxt   = S_DIV;
            end else begin
              chunk_nxt = chunk_r + 1'b1;
              start_nxt = chunk_end;
              state_nxt = S_PROP;
            end
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          csize_nxt = div_quo[CNT_W-1:0];
          state_nxt = S_PROP;
        end
      end
      S_PROP: begin
        if (size_r < CNT_W'(2)) begin
          searching_nxt = 1'b0;
          state_nxt     = S_OUT;
        end else if ((chunk_r < gran_r) && (start_r < {1'b0, size_r})) begin
          // non-empty chunk: build the trial by a rank scan
          if (chunk_end > {1'b0, size_r}) begin
            end_nxt = {1'b0, size_r};
          end else begin
            end_nxt = chunk_end;
          end
          idx_nxt   = '0;
          rank_nxt  = '0;
          state_nxt = S_SCAN;
        end else if (gran_r >= size_r) begin
          searching_nxt = 1'b0;
          state_nxt     = S_OUT;
        end else begin
          // finer split, capped at the set size
          if (gran_dbl > {1'b0, size_r}) begin
            gran_nxt = size_r;
          end else begin
            gran_nxt = gran_dbl[CNT_W-1:0];
          end
          chunk_nxt = '0;
          start_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_SCAN: begin
        prop_set_nxt[idx_r] = cur_bit && ((rank_r < start_r) || (rank_r >= end_r));
        if (cur_bit) begin
          rank_nxt = rank_r + 1'b1;
        end
        if (idx_r == IDX_W'(MAX_ITEMS - 1)) begin
          searching_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.trial_mask = mask_out;
          out_data_nxt.done_res   = !searching_r;
          out_data_nxt.kept_count = size_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      item_count_r <= ITEM_COUNT_RST;
      cur_set_r    <= '0;
      prop_set_r   <= '0;
      size_r       <= '0;
      gran_r       <= CNT_W'(2);
      chunk_r      <= '0;
      start_r      <= '0;
      end_r        <= '0;
      searching_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      item_count_r <= item_count_nxt;
      cur_set_r    <= cur_set_nxt;
      prop_set_r   <= prop_set_nxt;
      size_r       <= size_nxt;
      gran_r       <= gran_nxt;
      chunk_r      <= chunk_nxt;
      start_r      <= start_nxt;
      end_r        <= end_nxt;
      searching_r  <= searching_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    csize_r    <= csize_nxt;
    idx_r      <= idx_nxt;
    rank_r     <= rank_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule : delta_debug_min_sequencer_core

`default_nettype wire
